>>> hdl/look_at_view_matrix_top_macros.svh
// ----------------------------------------------------------------------------
// look_at_view_matrix_top_macros
// assertion helpers used by the look-at view matrix top level
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_TOP_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define LAVM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define LAVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`else

`define LAVM_ASSERT_SAME(lbl, ante, cons, msg)
`define LAVM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/lavm_pkg.sv
// ----------------------------------------------------------------------------
// lavm_pkg
// widths, payload types and constants of the look-at view matrix pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package lavm_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;

    // normalizer geometry
    localparam int MAG_W  = DATA_W + 1;
    localparam int VEC_W  = MAG_W + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int ROOT_W = MAG_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int Q_W    = FRAC_W + 1;
    localparam int UNIT_W = FRAC_W + 2;
    localparam int SIDE_W = 3 * DATA_W + 6 * UNIT_W;

    // product and sum widths
    localparam int XP_W  = DATA_W + UNIT_W;
    localparam int XD_W  = FRAC_W + VEC_W;
    localparam int SUM_W = XP_W + 2;
    localparam int T_W   = SUM_W - FRAC_W;
    localparam int NT_W  = T_W + 1;

    localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_W;
    localparam logic signed [NT_W-1:0] SAT_HI = NT_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [NT_W-1:0] SAT_LO = NT_W'(-(64'sd1 <<< (DATA_W - 1)));

    localparam logic [1:0] GRP_X    = 2'd0;
    localparam logic [1:0] GRP_Y    = 2'd1;
    localparam logic [1:0] GRP_Z    = 2'd2;
    localparam logic [1:0] GRP_LAST = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] tgt_x;
        logic signed [DATA_W-1:0] tgt_y;
        logic signed [DATA_W-1:0] tgt_z;
        logic signed [DATA_W-1:0] up_x;
        logic signed [DATA_W-1:0] up_y;
        logic signed [DATA_W-1:0] up_z;
    } in_t;

    typedef struct packed {
        logic [1:0]               group_index;
        logic signed [DATA_W-1:0] value_a;
        logic signed [DATA_W-1:0] value_b;
        logic signed [DATA_W-1:0] value_c;
        logic signed [DATA_W-1:0] value_d;
        logic                     last;
    } out_t;

endpackage

`default_nettype wire

>>> hdl/look_at_view_matrix_top.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// fixed-point look-at view matrix, emitted as four groups per transaction
// ----------------------------------------------------------------------------
// Each input transaction (eye, target, up in signed Q16.16) produces four
// output transactions holding the view matrix in storage order: the x, y and
// z rows of right, up and front padded with 0, then the negated translations
// and 1.0. The datapath is a 168-stage pipeline (three normalizers of 53
// stages each, with cross and dot product stages between them) followed by
// the output register. Items can enter on consecutive cycles until the
// pipeline fills; after that a new item is taken only as the output channel,
// carrying four groups per item, frees the output register. Backpressure
// on the output stalls the whole pipeline in place.
`default_nettype none

module look_at_view_matrix_top (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  lavm_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output lavm_pkg::out_t  m_data
);
    import lavm_pkg::*;
    `include "look_at_view_matrix_top_macros.svh"

    logic adv;

    // input and difference stages
    logic                    v0_reg, v1_reg;
    logic [2:0][DATA_W-1:0]  eye0_reg, tgt0_reg, up0_reg;
    logic [2:0][DATA_W:0]    diff1_reg;
    logic [2:0][DATA_W-1:0]  eye1_reg, up1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            eye0_reg <= {s_data.pos_z, s_data.pos_y, s_data.pos_x};
            tgt0_reg <= {s_data.tgt_z, s_data.tgt_y, s_data.tgt_x};
            up0_reg  <= {s_data.up_z, s_data.up_y, s_data.up_x};
            for (int i = 0; i < 3; i++) begin
                diff1_reg[i] <= {eye0_reg[i][DATA_W-1], eye0_reg[i]}
                              - {tgt0_reg[i][DATA_W-1], tgt0_reg[i]};
            end
            eye1_reg <= eye0_reg;
            up1_reg  <= up0_reg;
        end
    end

    // front = norm(eye - target)
    logic [2:0][VEC_W-1:0]   n1_in;
    logic                    n1_valid;
    logic [2:0][UNIT_W-1:0]  n1_vec;
    logic [SIDE_W-1:0]       n1_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_in[i] = {{(VEC_W - DATA_W - 1){diff1_reg[i][DATA_W]}}, diff1_reg[i]};
        end
    end

    lavm_norm u_norm_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v1_reg),
        .in_vec    (n1_in),
        .in_side   ({eye1_reg, up1_reg, {(SIDE_W - 6 * DATA_W){1'b0}}}),
        .out_valid (n1_valid),
        .out_vec   (n1_vec),
        .out_side  (n1_side)
    );

    logic [2:0][DATA_W-1:0] eye_n1, up_n1;
    assign eye_n1 = n1_side[SIDE_W-1 -: 3 * DATA_W];
    assign up_n1  = n1_side[SIDE_W-3*DATA_W-1 -: 3 * DATA_W];

    // right raw = up x front
    logic                    vc1a_reg, vc1b_reg;
    logic [2:0][XP_W-1:0]    pa1_reg, pb1_reg;
    logic [2:0][DATA_W-1:0]  eye_c1a_reg, eye_c1b_reg;
    logic [2:0][UNIT_W-1:0]  fr_c1a_reg, fr_c1b_reg;
    logic [2:0][VEC_W-1:0]   rraw_reg;

    for (genvar i = 0; i < 3; i++) begin : g_cross1
        localparam int I1 = (i + 1) % 3;
        localparam int I2 = (i + 2) % 3;
        logic signed [XP_W-1:0] a1, a2, b1, b2;
        logic signed [XD_W-1:0] pa, pb, d;

        assign a1 = $signed(up_n1[I1]);
        assign a2 = $signed(up_n1[I2]);
        assign b1 = $signed(n1_vec[I1]);
        assign b2 = $signed(n1_vec[I2]);
        assign pa = $signed(pa1_reg[i]);
        assign pb = $signed(pb1_reg[i]);
        assign d  = pa - pb;

        always_ff @(posedge aclk) begin
            if (adv) begin
                pa1_reg[i]  <= a1 * b2;
                pb1_reg[i]  <= a2 * b1;
                rraw_reg[i] <= d[XD_W-1:FRAC_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc1a_reg <= 1'b0;
            vc1b_reg <= 1'b0;
        end else if (adv) begin
            vc1a_reg <= n1_valid;
            vc1b_reg <= vc1a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            eye_c1a_reg <= eye_n1;
            fr_c1a_reg  <= n1_vec;
            eye_c1b_reg <= eye_c1a_reg;
            fr_c1b_reg  <= fr_c1a_reg;
        end
    end

    // right = norm(up x front)
    logic                    n2_valid;
    logic [2:0][UNIT_W-1:0]  n2_vec;
    logic [SIDE_W-1:0]       n2_side;

    lavm_norm u_norm_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vc1b_reg),
        .in_vec    (rraw_reg),
        .in_side   ({eye_c1b_reg, fr_c1b_reg, {(SIDE_W - 3 * DATA_W - 3 * UNIT_W){1'b0}}}),
        .out_valid (n2_valid),
        .out_vec   (n2_vec),
        .out_side  (n2_side)
    );

    logic [2:0][DATA_W-1:0] eye_n2;
    logic [2:0][UNIT_W-1:0] fr_n2;
    assign eye_n2 = n2_side[SIDE_W-1 -: 3 * DATA_W];
    assign fr_n2  = n2_side[SIDE_W-3*DATA_W-1 -: 3 * UNIT_W];

    // up raw = front x right
    logic                      vc2a_reg, vc2b_reg;
    logic [2:0][2*UNIT_W-1:0]  pa2_reg, pb2_reg;
    logic [2:0][DATA_W-1:0]    eye_c2a_reg, eye_c2b_reg;
    logic [2:0][UNIT_W-1:0]    fr_c2a_reg, fr_c2b_reg, rt_c2a_reg, rt_c2b_reg;
    logic [2:0][VEC_W-1:0]     uraw_reg;

    for (genvar i = 0; i < 3; i++) begin : g_cross2
        localparam int I1 = (i + 1) % 3;
        localparam int I2 = (i + 2) % 3;
        logic signed [2*UNIT_W-1:0] a1, a2, b1, b2;
        logic signed [XD_W-1:0]     pa, pb, d;

        assign a1 = $signed(fr_n2[I1]);
        assign a2 = $signed(fr_n2[I2]);
        assign b1 = $signed(n2_vec[I1]);
        assign b2 = $signed(n2_vec[I2]);
        assign pa = $signed(pa2_reg[i]);
        assign pb = $signed(pb2_reg[i]);
        assign d  = pa - pb;

        always_ff @(posedge aclk) begin
            if (adv) begin
                pa2_reg[i]  <= a1 * b2;
                pb2_reg[i]  <= a2 * b1;
                uraw_reg[i] <= d[XD_W-1:FRAC_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc2a_reg <= 1'b0;
            vc2b_reg <= 1'b0;
        end else if (adv) begin
            vc2a_reg <= n2_valid;
            vc2b_reg <= vc2a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            eye_c2a_reg <= eye_n2;
            fr_c2a_reg  <= fr_n2;
            rt_c2a_reg  <= n2_vec;
            eye_c2b_reg <= eye_c2a_reg;
            fr_c2b_reg  <= fr_c2a_reg;
            rt_c2b_reg  <= rt_c2a_reg;
        end
    end

    // up2 = norm(front x right)
    logic                    n3_valid;
    logic [2:0][UNIT_W-1:0]  n3_vec;
    logic [SIDE_W-1:0]       n3_side;

    lavm_norm u_norm_up (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vc2b_reg),
        .in_vec    (uraw_reg),
        .in_side   ({eye_c2b_reg, fr_c2b_reg, rt_c2b_reg}),
        .out_valid (n3_valid),
        .out_vec   (n3_vec),
        .out_side  (n3_side)
    );

    logic [2:0][DATA_W-1:0] eye_n3;
    logic [2:0][UNIT_W-1:0] fr_n3, rt_n3;
    assign eye_n3 = n3_side[SIDE_W-1 -: 3 * DATA_W];
    assign fr_n3  = n3_side[SIDE_W-3*DATA_W-1 -: 3 * UNIT_W];
    assign rt_n3  = n3_side[3*UNIT_W-1:0];

    // translations: basis 0 right, 1 up2, 2 front
    logic [2:0][UNIT_W-1:0]  basis [3];
    assign basis[0] = rt_n3;
    assign basis[1] = n3_vec;
    assign basis[2] = fr_n3;

    logic                    vd1_reg, vd2_reg, tv_reg;
    logic [2:0][XP_W-1:0]    dp_reg [3];
    logic [2:0][T_W-1:0]     t_reg;
    logic [2:0][DATA_W-1:0]  trans_reg;
    logic [2:0][UNIT_W-1:0]  rt_d1_reg, up_d1_reg, fr_d1_reg;
    logic [2:0][UNIT_W-1:0]  rt_d2_reg, up_d2_reg, fr_d2_reg;
    logic [2:0][UNIT_W-1:0]  rt_t_reg, up_t_reg, fr_t_reg;

    for (genvar b = 0; b < 3; b++) begin : g_dot
        logic signed [SUM_W-1:0] s;
        logic signed [NT_W-1:0]  n;

        always_comb begin
            s = '0;
            for (int c = 0; c < 3; c++) begin
                s = s + SUM_W'($signed(dp_reg[b][c]));
            end
            n = -NT_W'($signed(t_reg[b]));
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int c = 0; c < 3; c++) begin
                    dp_reg[b][c] <= XP_W'($signed(eye_n3[c])) * XP_W'($signed(basis[b][c]));
                end
                t_reg[b] <= s[SUM_W-1:FRAC_W];
                if (n > SAT_HI) begin
                    trans_reg[b] <= SAT_HI[DATA_W-1:0];
                end else if (n < SAT_LO) begin
                    trans_reg[b] <= SAT_LO[DATA_W-1:0];
                end else begin
                    trans_reg[b] <= n[DATA_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd1_reg <= 1'b0;
            vd2_reg <= 1'b0;
            tv_reg  <= 1'b0;
        end else if (adv) begin
            vd1_reg <= n3_valid;
            vd2_reg <= vd1_reg;
            tv_reg  <= vd2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rt_d1_reg <= rt_n3;
            up_d1_reg <= n3_vec;
            fr_d1_reg <= fr_n3;
            rt_d2_reg <= rt_d1_reg;
            up_d2_reg <= up_d1_reg;
            fr_d2_reg <= fr_d1_reg;
            rt_t_reg  <= rt_d2_reg;
            up_t_reg  <= up_d2_reg;
            fr_t_reg  <= fr_d2_reg;
        end
    end

    // output register: one matrix, sent as four groups
    logic                    ser_full_reg, ser_full_next;
    logic [1:0]              grp_reg, grp_next;
    logic [2:0][UNIT_W-1:0]  mrt_reg, mup_reg, mfr_reg;
    logic [2:0][DATA_W-1:0]  mtr_reg;
    logic                    ser_load;
    logic                    m_xfer;

    assign m_xfer   = ser_full_reg && m_ready;
    assign ser_load = tv_reg && (!ser_full_reg || (m_xfer && grp_reg == GRP_LAST));
    assign adv      = !tv_reg || ser_load;
    assign s_ready  = adv;

    always_comb begin
        ser_full_next = ser_full_reg;
        grp_next      = grp_reg;
        if (ser_load) begin
            ser_full_next = 1'b1;
            grp_next      = GRP_X;
        end else if (m_xfer) begin
            if (grp_reg == GRP_LAST) begin
                ser_full_next = 1'b0;
            end else begin
                grp_next = grp_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_full_reg <= 1'b0;
            grp_reg      <= GRP_X;
        end else begin
            ser_full_reg <= ser_full_next;
            grp_reg      <= grp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ser_load) begin
            mrt_reg <= rt_t_reg;
            mup_reg <= up_t_reg;
            mfr_reg <= fr_t_reg;
            mtr_reg <= trans_reg;
        end
    end

    function automatic logic [DATA_W-1:0] unit_ext(input logic [UNIT_W-1:0] u);
        return DATA_W'($signed(u));
    endfunction

    always_comb begin
        m_data.group_index = grp_reg;
        m_data.last        = (grp_reg == GRP_LAST);
        m_data.value_d     = '0;
        case (grp_reg)
            GRP_X: begin
                m_data.value_a = unit_ext(mrt_reg[0]);
                m_data.value_b = unit_ext(mup_reg[0]);
                m_data.value_c = unit_ext(mfr_reg[0]);
            end
            GRP_Y: begin
                m_data.value_a = unit_ext(mrt_reg[1]);
                m_data.value_b = unit_ext(mup_reg[1]);
                m_data.value_c = unit_ext(mfr_reg[1]);
            end
            GRP_Z: begin
                m_data.value_a = unit_ext(mrt_reg[2]);
                m_data.value_b = unit_ext(mup_reg[2]);
                m_data.value_c = unit_ext(mfr_reg[2]);
            end
            default: begin
                m_data.value_a = mtr_reg[0];
                m_data.value_b = mtr_reg[1];
                m_data.value_c = mtr_reg[2];
                m_data.value_d = ONE_FX;
            end
        endcase
    end

    assign m_valid = ser_full_reg;

    // a stalled tail item stays put until the output register takes it
    `LAVM_ASSERT_NEXT(a_tail_hold, tv_reg && !adv, tv_reg, "tail item lost during stall")
    // groups before the last are always followed by another group
    `LAVM_ASSERT_NEXT(a_more_groups, m_xfer && grp_reg != GRP_LAST, m_valid, "matrix cut short")
    // a fresh load always starts at the first group
    `LAVM_ASSERT_NEXT(a_load_first, ser_load, m_valid && grp_reg == GRP_X, "load not at group 0")
    // output register drains after the last group if nothing was loaded
    `LAVM_ASSERT_NEXT(a_drain, m_xfer && grp_reg == GRP_LAST && !ser_load, !m_valid,
        "spurious group after last")
    // the tail moves only into the output register
    `LAVM_ASSERT_SAME(a_adv_load, tv_reg && adv, ser_load, "tail advanced without load")

endmodule

`default_nettype wire

>>> hdl/lavm_norm.sv
// ----------------------------------------------------------------------------
// lavm_norm
// pipelined 3-vector normalizer: squares, bit-per-stage square root,
// bit-per-stage restoring division of each component by the length
// ----------------------------------------------------------------------------
`default_nettype none

module lavm_norm (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     en,
    input  logic                                     in_valid,
    input  logic [2:0][lavm_pkg::VEC_W-1:0]          in_vec,
    input  logic [lavm_pkg::SIDE_W-1:0]              in_side,
    output logic                                     out_valid,
    output logic [2:0][lavm_pkg::UNIT_W-1:0]         out_vec,
    output logic [lavm_pkg::SIDE_W-1:0]              out_side
);
    import lavm_pkg::*;

    // magnitude stage
    logic                   va_reg;
    logic [2:0][MAG_W-1:0]  maga_reg;
    logic [2:0]             nega_reg;
    logic [SIDE_W-1:0]      sidea_reg;
    logic [2:0][MAG_W-1:0]  mag_next;

    always_comb begin
        logic [VEC_W-1:0] t;
        for (int i = 0; i < 3; i++) begin
            t = in_vec[i][VEC_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
            mag_next[i] = t[MAG_W-1:0];
        end
    end

    // square stage
    logic                   vb_reg;
    logic [2:0][SQ_W-1:0]   sqb_reg;
    logic [2:0][MAG_W-1:0]  magb_reg;
    logic [2:0]             negb_reg;
    logic [SIDE_W-1:0]      sideb_reg;

    // square root stages, index 0 holds the sum of squares
    logic                   vs_reg    [0:ROOT_W];
    logic [SQ_W-1:0]        rad_reg   [0:ROOT_W];
    logic [REM_W-1:0]       rem_reg   [0:ROOT_W];
    logic [ROOT_W-1:0]      root_reg  [0:ROOT_W];
    logic [2:0][MAG_W-1:0]  mags_reg  [0:ROOT_W];
    logic [2:0]             negs_reg  [0:ROOT_W];
    logic [SIDE_W-1:0]      sides_reg [0:ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            vs_reg[0] <= 1'b0;
        end else if (en) begin
            va_reg    <= in_valid;
            vb_reg    <= va_reg;
            vs_reg[0] <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            maga_reg  <= mag_next;
            for (int i = 0; i < 3; i++) begin
                nega_reg[i] <= in_vec[i][VEC_W-1];
                sqb_reg[i]  <= maga_reg[i] * maga_reg[i];
            end
            sidea_reg <= in_side;
            magb_reg  <= maga_reg;
            negb_reg  <= nega_reg;
            sideb_reg <= sidea_reg;
            rad_reg[0]   <= sqb_reg[0] + sqb_reg[1] + sqb_reg[2];
            rem_reg[0]   <= '0;
            root_reg[0]  <= '0;
            mags_reg[0]  <= magb_reg;
            negs_reg[0]  <= negb_reg;
            sides_reg[0] <= sideb_reg;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] diff;
        logic             take;

        assign rem_sh = {rem_reg[k], rad_reg[k][SQ_W-1 -: 2]};
        assign trial  = {{(REM_W - ROOT_W){1'b0}}, root_reg[k], 2'b01};
        assign diff   = rem_sh - trial;
        assign take   = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vs_reg[k+1] <= 1'b0;
            end else if (en) begin
                vs_reg[k+1] <= vs_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k+1]   <= {rad_reg[k][SQ_W-3:0], 2'b00};
                rem_reg[k+1]   <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                root_reg[k+1]  <= {root_reg[k][ROOT_W-2:0], take};
                mags_reg[k+1]  <= mags_reg[k];
                negs_reg[k+1]  <= negs_reg[k];
                sides_reg[k+1] <= sides_reg[k];
            end
        end
    end

    // division stages: quotient never exceeds one, so Q_W steps suffice
    logic                   vd_reg    [1:Q_W];
    logic [MAG_W-1:0]       len_reg   [1:Q_W];
    logic [2:0][MAG_W-1:0]  r_reg     [1:Q_W];
    logic [2:0][Q_W-1:0]    q_reg     [1:Q_W];
    logic [2:0]             negd_reg  [1:Q_W];
    logic [SIDE_W-1:0]      sided_reg [1:Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        logic                   src_v;
        logic [MAG_W-1:0]       src_len;
        logic [2:0][MAG_W-1:0]  src_r;
        logic [2:0][Q_W-1:0]    src_q;
        logic [2:0]             src_bit;
        logic [2:0]             src_neg;
        logic [SIDE_W-1:0]      src_side;
        logic [2:0][MAG_W-1:0]  r_new;
        logic [2:0][Q_W-1:0]    q_new;

        if (j == 0) begin : g_first
            // numerator is mag * 2^FRAC_W; its top part mag >> 1 is below the length
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    src_r[i]   = {1'b0, mags_reg[ROOT_W][i][MAG_W-1:1]};
                    src_bit[i] = mags_reg[ROOT_W][i][0];
                end
            end
            assign src_v    = vs_reg[ROOT_W];
            assign src_len  = root_reg[ROOT_W];
            assign src_q    = '0;
            assign src_neg  = negs_reg[ROOT_W];
            assign src_side = sides_reg[ROOT_W];
        end else begin : g_next
            assign src_v    = vd_reg[j];
            assign src_len  = len_reg[j];
            assign src_r    = r_reg[j];
            assign src_q    = q_reg[j];
            assign src_bit  = '0;
            assign src_neg  = negd_reg[j];
            assign src_side = sided_reg[j];
        end

        always_comb begin
            logic [MAG_W:0] r_sh;
            logic [MAG_W:0] r_sub;
            logic           take;
            for (int i = 0; i < 3; i++) begin
                r_sh     = {src_r[i], src_bit[i]};
                r_sub    = r_sh - {1'b0, src_len};
                take     = (r_sh >= {1'b0, src_len});
                r_new[i] = take ? r_sub[MAG_W-1:0] : r_sh[MAG_W-1:0];
                q_new[i] = {src_q[i][Q_W-2:0], take};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vd_reg[j+1] <= 1'b0;
            end else if (en) begin
                vd_reg[j+1] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                len_reg[j+1]   <= src_len;
                r_reg[j+1]     <= r_new;
                q_reg[j+1]     <= q_new;
                negd_reg[j+1]  <= src_neg;
                sided_reg[j+1] <= src_side;
            end
        end
    end

    // a zero-length vector has all components zero and stays zero
    always_comb begin
        logic [UNIT_W-1:0] u;
        for (int i = 0; i < 3; i++) begin
            u = {1'b0, q_reg[Q_W][i]};
            if (len_reg[Q_W] == '0) begin
                out_vec[i] = '0;
            end else begin
                out_vec[i] = negd_reg[Q_W][i] ? (~u + 1'b1) : u;
            end
        end
    end

    assign out_valid = vd_reg[Q_W];
    assign out_side  = sided_reg[Q_W];

endmodule

`default_nettype wire

>>> tb/look_at_view_matrix_top_tb.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_top_tb
// self-checking bench for the fixed-point look-at view matrix
// ----------------------------------------------------------------------------
// Drives a table of directed eye/target/up sets, then random sets, through
// the input channel. Every accepted transaction is turned into four expected
// matrix groups by a bit-exact model of the math or a fixed all-zero or
// identity set. Each output transaction is compared field by field with the
// oldest expected group. Idling on both channels moves through three phases.
`default_nettype none

module look_at_view_matrix_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lavm_pkg::*;

    localparam longint FX_ONE    = 64'sd1 <<< FRAC_W;
    localparam int     WDOG_MAX  = 5000;
    localparam int     DRAIN_CYC = 200;
    localparam int     N_RANDOM  = 320;

    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_ZERO,
        EXP_IDENTITY
    } exp_kind_t;

    typedef struct {
        in_t       data;
        exp_kind_t kind;
    } stim_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    out_t      group_q[$];
    stim_row_t rows[$];
    int        n_fail;
    int        n_items;
    int        n_groups;
    int        idle_cycles;
    int        tx_idle_pct;
    int        rx_idle_pct;

    look_at_view_matrix_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic longint clamp_fx(input longint v);
        longint hi;
        hi = (64'sd1 <<< (DATA_W - 1)) - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < -hi - 1) begin
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic void normalize(input longint v[3], output longint o[3]);
        logic [127:0] sumsq;
        logic [127:0] m;
        logic [127:0] cand;
        logic [63:0]  root;
        logic [127:0] quot;
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
            m = 128'(v[i] < 0 ? -v[i] : v[i]);
            sumsq = sumsq + m * m;
        end
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = 128'(root | (64'd1 << b));
            if (cand * cand <= sumsq) begin
                root = cand[63:0];
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (root == 0) begin
                o[i] = v[i];
            end else begin
                m = 128'(v[i] < 0 ? -v[i] : v[i]);
                quot = (m << FRAC_W) / 128'(root);
                o[i] = v[i] < 0 ? -longint'(quot[63:0]) : longint'(quot[63:0]);
            end
        end
    endfunction

    // plain a x b, each component floored back to fixed point
    function automatic void cross_fx(input longint a[3], input longint b[3],
                                     output longint o[3]);
        o[0] = (a[1] * b[2] - a[2] * b[1]) >>> FRAC_W;
        o[1] = (a[2] * b[0] - a[0] * b[2]) >>> FRAC_W;
        o[2] = (a[0] * b[1] - a[1] * b[0]) >>> FRAC_W;
    endfunction

    function automatic longint neg_dot_fx(input longint a[3], input longint b[3]);
        longint s;
        s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        return clamp_fx(-(s >>> FRAC_W));
    endfunction

    task automatic predict_matrix(input in_t d);
        longint eye[3], diff[3], upv[3], front[3], rraw[3], right[3];
        longint uraw[3], up2[3];
        longint trans[3];
        out_t   g;
        eye[0] = d.pos_x;
        eye[1] = d.pos_y;
        eye[2] = d.pos_z;
        upv[0] = d.up_x;
        upv[1] = d.up_y;
        upv[2] = d.up_z;
        diff[0] = eye[0] - longint'(d.tgt_x);
        diff[1] = eye[1] - longint'(d.tgt_y);
        diff[2] = eye[2] - longint'(d.tgt_z);
        normalize(diff, front);
        cross_fx(upv, front, rraw);
        normalize(rraw, right);
        cross_fx(front, right, uraw);
        normalize(uraw, up2);
        trans[0] = neg_dot_fx(eye, right);
        trans[1] = neg_dot_fx(eye, up2);
        trans[2] = neg_dot_fx(eye, front);
        for (int i = 0; i < 3; i++) begin
            g.group_index = 2'(i);
            g.value_a     = DATA_W'(clamp_fx(right[i]));
            g.value_b     = DATA_W'(clamp_fx(up2[i]));
            g.value_c     = DATA_W'(clamp_fx(front[i]));
            g.value_d     = '0;
            g.last        = 1'b0;
            group_q.push_back(g);
        end
        g.group_index = GRP_LAST;
        g.value_a     = DATA_W'(trans[0]);
        g.value_b     = DATA_W'(trans[1]);
        g.value_c     = DATA_W'(trans[2]);
        g.value_d     = ONE_FX;
        g.last        = 1'b1;
        group_q.push_back(g);
    endtask

    // typed expectation: all-zero rotation or identity, no translation
    task automatic push_fixed(input logic ident);
        out_t g;
        for (int i = 0; i < 4; i++) begin
            g.group_index = 2'(i);
            g.value_a     = (ident && i == 0) ? ONE_FX : '0;
            g.value_b     = (ident && i == 1) ? ONE_FX : '0;
            g.value_c     = (ident && i == 2) ? ONE_FX : '0;
            g.value_d     = (i == 3) ? ONE_FX : '0;
            g.last        = (i == 3);
            group_q.push_back(g);
        end
    endtask

    function automatic in_t make_in(input longint px, py, pz, tx, ty, tz,
                                    ux, uy, uz);
        in_t d;
        d.pos_x = DATA_W'(px);
        d.pos_y = DATA_W'(py);
        d.pos_z = DATA_W'(pz);
        d.tgt_x = DATA_W'(tx);
        d.tgt_y = DATA_W'(ty);
        d.tgt_z = DATA_W'(tz);
        d.up_x  = DATA_W'(ux);
        d.up_y  = DATA_W'(uy);
        d.up_z  = DATA_W'(uz);
        return d;
    endfunction

    function automatic logic [DATA_W-1:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return DATA_W'(longint'($urandom_range(40)) * FX_ONE / 4 - 5 * FX_ONE);
            2: return DATA_W'($urandom_range(2000)) - DATA_W'(1000);
            default: return DATA_W'(int'($urandom) >>> $urandom_range(24));
        endcase
    endfunction

    task automatic send_item(input in_t d, input exp_kind_t kind);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = d;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        case (kind)
            EXP_ZERO:     push_fixed(1'b0);
            EXP_IDENTITY: push_fixed(1'b1);
            default:      predict_matrix(d);
        endcase
        n_items++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic check_field(input string name, input longint exp_v,
                               input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: mismatch %s expected %0d actual %0d", $time, name,
                     exp_v, act_v);
            n_fail++;
        end
    endtask

    always @(posedge aclk) begin
        out_t e;
        if (aresetn && m_valid && m_ready) begin
            n_groups++;
            if (group_q.size() == 0) begin
                $display("%0t: unexpected output transaction %h", $time, m_data);
                n_fail++;
            end else begin
                e = group_q.pop_front();
                check_field("group_index", e.group_index, m_data.group_index);
                check_field("value_a", e.value_a, m_data.value_a);
                check_field("value_b", e.value_b, m_data.value_b);
                check_field("value_c", e.value_c, m_data.value_c);
                check_field("value_d", e.value_d, m_data.value_d);
                check_field("last", e.last, m_data.last);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired with %0d groups pending", group_q.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        longint mx, mn, one;
        mx  = 64'sd2147483647;
        mn  = -64'sd2147483648;
        one = FX_ONE;
        n_fail      = 0;
        n_items     = 0;
        n_groups    = 0;
        idle_cycles = 0;
        tx_idle_pct = 13;
        rx_idle_pct = 69;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // zero-length front, right and up all collapse to zero
        rows.push_back('{make_in(0, 0, 0, 0, 0, 0, 0, 0, 0), EXP_ZERO});
        rows.push_back('{make_in(0, 0, 0, 0, 0, 0, one, one, one), EXP_ZERO});
        rows.push_back('{make_in(0, 0, 0, 0, 0, -one, 0, one, 0), EXP_IDENTITY});
        rows.push_back('{make_in(0, 0, one, 0, 0, 0, 0, 2 * one, 0), EXP_MODEL});
        rows.push_back('{make_in(3 * one, 0, 0, 3 * one, 0, 0, 0, one, 0), EXP_MODEL});
        rows.push_back('{make_in(one, 2 * one, 3 * one, 0, 0, 0, 0, one, 0), EXP_MODEL});
        // up parallel to front: right is zero-length
        rows.push_back('{make_in(0, 5 * one, 0, 0, 0, 0, 0, one, 0), EXP_MODEL});
        rows.push_back('{make_in(mx, mx, mx, mn, mn, mn, mx, mx, mx), EXP_MODEL});
        rows.push_back('{make_in(mn, mn, mn, mx, mx, mx, mn, mn, mn), EXP_MODEL});
        rows.push_back('{make_in(mx, mn, mx, mn, mx, mn, mn, mx, mn), EXP_MODEL});
        rows.push_back('{make_in(mn, 0, 0, mx, 0, 0, 0, mx, 0), EXP_MODEL});
        rows.push_back('{make_in(mx, mx, mx, 0, 0, 0, 0, one, 0), EXP_MODEL});
        rows.push_back('{make_in(mn, mn, mn, 0, 0, 0, 0, 0, one), EXP_MODEL});
        rows.push_back('{make_in(1, 0, 0, 0, 0, 0, 0, 1, 0), EXP_MODEL});
        rows.push_back('{make_in(-1, -1, -1, 0, 0, 0, 1, -1, 1), EXP_MODEL});
        rows.push_back('{make_in(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                                 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                                 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555),
                         EXP_MODEL});
        rows.push_back('{make_in(-7 * one, 4 * one, 10 * one, one, -one, 0,
                                 0, one, 0), EXP_MODEL});
        rows.push_back('{make_in(mx, mx, mx, mx, mx, mx, mx, mx, mx), EXP_ZERO});
        foreach (rows[i]) begin
            send_item(rows[i].data, rows[i].kind);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            in_t d;
            if (n == N_RANDOM / 3) begin
                tx_idle_pct = 69;
                rx_idle_pct = 13;
            end else if (n == 2 * N_RANDOM / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            d = make_in(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord());
            // now and then look straight along up, or sit on the target
            case ($urandom_range(15))
                0: begin
                    d.tgt_x = d.pos_x;
                    d.tgt_y = d.pos_y;
                    d.tgt_z = d.pos_z;
                end
                1: begin
                    d.up_x = d.pos_x - d.tgt_x;
                    d.up_y = d.pos_y - d.tgt_y;
                    d.up_z = d.pos_z - d.tgt_z;
                end
                default: ;
            endcase
            send_item(d, EXP_MODEL);
        end

        wait (group_q.size() == 0);
        repeat (DRAIN_CYC) @(posedge aclk);
        $display("sent %0d look-at transactions (directed and random), checked %0d",
                 n_items, n_groups);
        $display("matrix groups across three idling phases, %0d mismatches", n_fail);
        if (n_fail == 0 && group_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> look_at_view_matrix_top.f
+incdir+hdl
hdl/lavm_pkg.sv
hdl/lavm_norm.sv
hdl/look_at_view_matrix_top.sv
tb/look_at_view_matrix_top_tb.sv
